// ----- sv/fbd_pkg.sv -----
// ----------------------------------------------------------------------------
// fbd_pkg
// Shared types and codes for the framebuffer draw engine.
// ----------------------------------------------------------------------------
package fbd_pkg;

  typedef enum logic [1:0] {
    REQ_PIXEL = 2'd0,
    REQ_LINE  = 2'd1,
    REQ_FILL  = 2'd2,
    REQ_STEP  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CFG_COLOR  = 2'd0,
    CFG_ORG_X  = 2'd1,
    CFG_ORG_Y  = 2'd2,
    CFG_FWIDTH = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_LINE = 2'd1,
    MODE_FILL = 2'd2
  } mode_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture accepted item, set up run
    logic div_start; // start minor-coordinate division
    logic emit;      // compute pixel and load output register
    logic advance;   // move run position along with emit
  } fbd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic produce;   // loaded item yields a pixel
    logic is_line;   // produced pixel needs the divider
    logic div_done;
  } fbd_stat_t;

endpackage

// ----- sv/fbd_div.sv -----
// ----------------------------------------------------------------------------
// fbd_div
// Restoring signed divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module fbd_div #(
  parameter int NUM_BITS = 30,
  parameter int DEN_BITS = 15
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [NUM_BITS-1:0] num,
  input  logic        [DEN_BITS-1:0] den,
  output logic                       done,
  output logic signed [NUM_BITS-1:0] quot
);
  localparam int CW = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] q_reg;
  logic [DEN_BITS:0]   rem;
  logic [DEN_BITS-1:0] den_reg;
  logic                neg;
  logic [CW-1:0]       cnt;
  logic                busy;
  logic [DEN_BITS:0]   rem_sh;

  assign rem_sh = {rem[DEN_BITS-1:0], q_reg[NUM_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        cnt     <= CW'(NUM_BITS);
        neg     <= num[NUM_BITS-1];
        q_reg   <= num[NUM_BITS-1] ? -num : num;
        rem     <= '0;
        den_reg <= den;
      end else if (busy) begin
        if (rem_sh >= {1'b0, den_reg}) begin
          rem   <= rem_sh - {1'b0, den_reg};
          q_reg <= {q_reg[NUM_BITS-2:0], 1'b1};
        end else begin
          rem   <= rem_sh;
          q_reg <= {q_reg[NUM_BITS-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = neg ? -$signed(q_reg) : $signed(q_reg);
endmodule

// ----- sv/fbd_ctrl.sv -----
// ----------------------------------------------------------------------------
// fbd_ctrl
// Sequencer: accept item, wait on divider for line pixels, hand out result; items that yield nothing return to idle.
// ----------------------------------------------------------------------------
module fbd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output fbd_pkg::fbd_cmd_t cmd,
  input  fbd_pkg::fbd_stat_t stat
);
  import fbd_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CHECK, S_DIV, S_OUT} state_t;
  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.load      = in_valid && in_ready;
    cmd.div_start = (state == S_CHECK) && stat.produce && stat.is_line;
    cmd.emit      = ((state == S_CHECK) && stat.produce && !stat.is_line) ||
                    ((state == S_DIV) && stat.div_done);
    cmd.advance   = cmd.emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_CHECK;
        S_CHECK: begin
          if (!stat.produce) state <= S_IDLE;
          else if (stat.is_line) state <= S_DIV;
          else begin
            state <= S_OUT;
            out_valid <= 1'b1;
          end
        end
        S_DIV: if (stat.div_done) begin
          state <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: if (out_ready) begin
          state <= S_IDLE;
          out_valid <= 1'b0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> state == S_OUT)
    else $error("result shown outside output state");
  assert property (@(posedge clk) disable iff (rst) (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst) in_ready |-> !out_valid)
    else $error("accept while result pending");
endmodule

// ----- sv/fbd_dp.sv -----
// ----------------------------------------------------------------------------
// fbd_dp
// Datapath: run state, line/fill walk, divider and pixel index.
// ----------------------------------------------------------------------------
module fbd_dp #(
  parameter int COORD_BITS = 13,
  parameter int INDEX_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  fbd_pkg::fbd_cmd_t            cmd,
  output fbd_pkg::fbd_stat_t           stat,
  input  logic [1:0]                   req_type,
  input  logic signed [COORD_BITS-1:0] x_start,
  input  logic signed [COORD_BITS-1:0] y_start,
  input  logic signed [COORD_BITS-1:0] x_end_or_width,
  input  logic signed [COORD_BITS-1:0] y_end_or_height,
  input  logic [31:0]                  pixel_color,
  input  logic signed [COORD_BITS-1:0] origin_x,
  input  logic signed [COORD_BITS-1:0] origin_y,
  input  logic [COORD_BITS-1:0]        frame_width,
  output logic [INDEX_BITS-1:0]        pixel_index,
  output logic [31:0]                  write_color,
  output logic                         last,
  output logic                         offscreen
);
  import fbd_pkg::*;

  localparam int W  = COORD_BITS + 1;        // positions and spans
  localparam int NB = 2 * COORD_BITS + 4;    // 2*d*t
  // unwrapped index, wide enough for the products and the range compare
  localparam int IB = (2 * COORD_BITS + 4 > INDEX_BITS + 1) ?
                      2 * COORD_BITS + 4 : INDEX_BITS + 2;

  mode_t mode;
  logic  major_is_x;
  logic  single;                 // pending pixel command / degenerate line
  logic  produce;
  logic signed [W-1:0] walk_pos, row_pos;
  logic signed [W-1:0] first_x, first_y, second_x, second_y;

  // Item decode
  logic signed [W-1:0] x1, y1, x2, y2, dx, dy;
  logic                mx, swp;
  always_comb begin
    x1 = W'(x_start);
    y1 = W'(y_start);
    x2 = W'(x_end_or_width);
    y2 = W'(y_end_or_height);
    dx = (x1 > x2) ? x1 - x2 : x2 - x1;
    dy = (y1 > y2) ? y1 - y2 : y2 - y1;
    mx = (dx >= dy);
    swp = mx ? (x1 > x2) : (y1 > y2);
  end

  // Line geometry
  logic signed [W-1:0] a_maj, a_min, b_maj, b_min, len, dmin;
  logic                is_last_line;
  always_comb begin
    a_maj = major_is_x ? first_x : first_y;
    a_min = major_is_x ? first_y : first_x;
    b_maj = major_is_x ? second_x : second_y;
    b_min = major_is_x ? second_y : second_x;
    len   = b_maj - a_maj;
    dmin  = b_min - a_min;
    is_last_line = (walk_pos >= len);
  end

  logic signed [NB-1:0] prod;
  always_ff @(posedge clk) prod <= NB'(dmin) * NB'(walk_pos) * NB'(2);

  logic signed [NB-1:0] quot;
  logic                 div_done;
  logic                 div_go;
  always_ff @(posedge clk) begin
    if (rst) div_go <= 1'b0;
    else div_go <= cmd.div_start;
  end

  fbd_div #(.NUM_BITS(NB), .DEN_BITS(W)) u_div (
    .clk(clk), .rst(rst), .start(div_go), .num(prod),
    .den(len), .done(div_done), .quot(quot)
  );

  // Pixel coordinate selection
  logic signed [NB-1:0] mn_w;
  logic signed [W-1:0]  px, py, mn;
  logic                 lst;
  logic                 row_end, fill_last;
  always_comb begin
    mn_w = (NB'(a_min) * NB'(2) + quot + NB'(1)) / NB'(2);
    mn   = W'(mn_w);
    row_end   = (walk_pos + W'(1) >= second_x);
    fill_last = row_end && (row_pos + W'(1) >= second_y);
    if (single) begin
      px = first_x; py = first_y; lst = 1'b1;
    end else if (mode == MODE_LINE) begin
      px  = major_is_x ? a_maj + walk_pos : mn;
      py  = major_is_x ? mn : a_maj + walk_pos;
      lst = is_last_line;
    end else begin
      px  = first_x + walk_pos;
      py  = first_y + row_pos;
      lst = fill_last;
    end
  end

  // Index: combinational multiply and add; the result is registered on emit
  logic signed [IB-1:0] sx, sy, rowterm, idx;
  always_comb begin
    sx = IB'(origin_x) + IB'(px);
    sy = IB'(origin_y) + IB'(py);
    rowterm = $signed({1'b0, frame_width}) * sy;
    idx = sx + rowterm;
  end

  assign stat.produce  = produce;
  assign stat.is_line  = (mode == MODE_LINE) && !single;
  assign stat.div_done = div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      major_is_x <= 1'b0;
      single <= 1'b0;
      produce <= 1'b0;
      walk_pos <= '0; row_pos <= '0;
      first_x <= '0; first_y <= '0; second_x <= '0; second_y <= '0;
    end else begin
      if (cmd.load) begin
        single <= 1'b0;
        if (req_type == REQ_STEP) begin
          produce <= (mode == MODE_LINE) || (mode == MODE_FILL);
        end else begin
          walk_pos <= '0;
          row_pos  <= '0;
          mode     <= MODE_IDLE;
          produce  <= 1'b1;
          unique case (req_type)
            REQ_PIXEL: begin
              single <= 1'b1; first_x <= x1; first_y <= y1;
            end
            REQ_LINE: begin
              if (dx == '0 && dy == '0) begin
                single <= 1'b1; first_x <= x1; first_y <= y1;
              end else begin
                major_is_x <= mx;
                mode <= MODE_LINE;
                first_x  <= swp ? x2 : x1;
                first_y  <= swp ? y2 : y1;
                second_x <= swp ? x1 : x2;
                second_y <= swp ? y1 : y2;
              end
            end
            default: begin
              if (x2 <= 0 || y2 <= 0) produce <= 1'b0;
              else begin
                mode <= MODE_FILL;
                first_x <= x1; first_y <= y1;
                second_x <= x2; second_y <= y2;
              end
            end
          endcase
        end
      end
      if (cmd.advance && !single) begin
        if (mode == MODE_LINE) begin
          if (is_last_line) mode <= MODE_IDLE;
          else walk_pos <= walk_pos + W'(1);
        end else begin
          if (fill_last) mode <= MODE_IDLE;
          else if (row_end) begin
            walk_pos <= '0;
            row_pos  <= row_pos + W'(1);
          end else walk_pos <= walk_pos + W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pixel_index <= idx[INDEX_BITS-1:0];
      write_color <= pixel_color;
      last        <= lst;
      offscreen   <= (idx < 0) || (idx >= (IB'(1) <<< INDEX_BITS));
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(stat.is_line && !div_done))
    else $error("line pixel emitted before division finished");
  assert property (@(posedge clk) disable iff (rst)
    (cmd.advance && mode == MODE_LINE && !single && !is_last_line)
      |=> walk_pos == $past(walk_pos) + W'(1))
    else $error("line walk did not advance");
  assert property (@(posedge clk) disable iff (rst) mode != 2'd3)
    else $error("bad run mode");
endmodule

// ----- sv/framebuffer_draw_engine_unit.sv -----
// ----------------------------------------------------------------------------
// framebuffer_draw_engine_unit
// 2D pixel/line/fill draw engine emitting at most one framebuffer write per item.
// ----------------------------------------------------------------------------
// One item is handled at a time. A pixel, a fill pixel or a degenerate line
// passes through the check state and then shows its result; a line pixel
// also waits in the divide state for the bit-serial divider that computes
// the minor coordinate. The engine returns to idle and takes the next item
// once the result is taken. A step that yields nothing returns the engine
// to idle straight from the check state.
module framebuffer_draw_engine_unit #(
  parameter int COORD_BITS = 13,
  parameter int INDEX_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [31:0]                  cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   req_type,
  input  logic signed [COORD_BITS-1:0] x_start,
  input  logic signed [COORD_BITS-1:0] y_start,
  input  logic signed [COORD_BITS-1:0] x_end_or_width,
  input  logic signed [COORD_BITS-1:0] y_end_or_height,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [INDEX_BITS-1:0]        pixel_index,
  output logic [31:0]                  write_color,
  output logic                         last,
  output logic                         offscreen
);
  import fbd_pkg::*;

  logic [31:0]                  pixel_color;
  logic signed [COORD_BITS-1:0] origin_x, origin_y;
  logic [COORD_BITS-1:0]        frame_width;
  fbd_cmd_t  cmd;
  fbd_stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_color <= '0;
      origin_x    <= '0;
      origin_y    <= '0;
      frame_width <= COORD_BITS'(640);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_COLOR:  pixel_color <= cfg_data;
        CFG_ORG_X:  origin_x    <= cfg_data[COORD_BITS-1:0];
        CFG_ORG_Y:  origin_y    <= cfg_data[COORD_BITS-1:0];
        CFG_FWIDTH: frame_width <= cfg_data[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  fbd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .stat(stat)
  );

  fbd_dp #(.COORD_BITS(COORD_BITS), .INDEX_BITS(INDEX_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .req_type(req_type), .x_start(x_start), .y_start(y_start),
    .x_end_or_width(x_end_or_width), .y_end_or_height(y_end_or_height),
    .pixel_color(pixel_color), .origin_x(origin_x), .origin_y(origin_y),
    .frame_width(frame_width), .pixel_index(pixel_index),
    .write_color(write_color), .last(last), .offscreen(offscreen)
  );
endmodule
